// File: hw/rtl/nts_pkg.sv
// Shared types and constants for the nearest timestamp search block.
`timescale 1ns / 1ps

package nts_pkg;

   localparam int STAMP_W         = 63;
   localparam int INDEX_W         = 10;
   localparam int TABLE_DEPTH_DEF = 1024;

   // request command codes
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } command_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_MID,
      ST_PROBE,
      ST_NEIGHBOR,
      ST_PICK,
      ST_DONE
   } ctrl_state_type;

   // table read address select
   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID,
      RD_DEC,
      RD_INC
   } rd_sel_type;

   // search result select
   typedef enum logic [2:0] {
      RES_ZERO,
      RES_LAST,
      RES_MID,
      RES_PICK,
      RES_EMPTY
   } res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        accept;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        set_mid;
      logic        init_bounds;
      logic        hi_to_mid;
      logic        lo_to_inc;
      logic        latch_vmid;
      logic        latch_diff;
      logic        set_result;
      res_sel_type res_sel;
      logic        load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       count_zero;
      logic       tgt_lt_q;
      logic       tgt_gt_q;
      logic       q_eq;
      logic       lo_lt_hi;
      logic       mid_nz;
      logic       mid_inc_lt_n;
      logic       side_high;
      logic       rsp_free;
   } dp_status_type;

endpackage

// File: hw/rtl/nts_if.sv
// Request and response channel interfaces of the nearest timestamp search block.
`timescale 1ns / 1ps

interface nts_req_if
   import nts_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [STAMP_W-1:0] stamp_value;

   modport source (output valid, output command, output stamp_value, input ready);
   modport sink   (input valid, input command, input stamp_value, output ready);
endinterface

interface nts_rsp_if
   import nts_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] nearest_index;
   logic               table_empty;
   logic               appends_dropped;

   modport source (output valid, output nearest_index, output table_empty,
                   output appends_dropped, input ready);
   modport sink   (input valid, input nearest_index, input table_empty,
                   input appends_dropped, output ready);
endinterface

// File: hw/rtl/nearest_timestamp_search_top.sv
// Top level of the nearest timestamp search block.
`timescale 1ns / 1ps
//
// Usage: req_chan carries one request per valid/ready handshake: command
// clear (empties the table and the dropped flag), append (stores
// stamp_value at the next free entry, or sets the dropped flag when full)
// or query (finds the stored entry nearest stamp_value). Only a query
// produces a response on rsp_chan; code 3 is ignored.
// Clear and append leave the request side open, and the next request can be taken in
// the following cycle. A query closes the request side until its response
// is loaded: on an empty table the response is loaded straight away, when
// the target is at or below the first entry after the first-entry read and
// when it is at or above the last after the last-entry read. Otherwise the
// two end reads are followed by search steps, each a probe read and, where
// needed, a neighbor read, until a probe matches, the bounds meet or a
// neighbor check picks the nearer entry. The request side reopens in the
// cycle after the response is loaded. The single read port of the table
// memory has registered read data: each probe and neighbor check is one read.
// The response sits in an output register; a new request is accepted
// while it waits, but a finished query holds until the register frees.
// Reset clears the fill count, the dropped flag and the response valid;
// table contents are not cleared, and entries past the count are never read.
//
module nearest_timestamp_search_top
   import nts_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   nts_req_if.sink   req_chan,
   nts_rsp_if.source rsp_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   nts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   nts_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_chan.command),
      .req_stamp_value     (req_chan.stamp_value),
      .cmd                 (dp_cmd),
      .status              (dp_status),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_nearest_index   (rsp_chan.nearest_index),
      .rsp_table_empty     (rsp_chan.table_empty),
      .rsp_appends_dropped (rsp_chan.appends_dropped)
   );

   // a query keeps the request side closed on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready && req_chan.command == CMD_QUERY) |=> !req_ready)
      else $error("request side open right after a query");

   // a response is never loaded over one that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |-> dp_status.rsp_free)
      else $error("response register overwritten");

   // an empty table reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.table_empty) |-> (rsp_chan.nearest_index == '0))
      else $error("empty response with nonzero index");

endmodule

// File: hw/rtl/nts_ctrl.sv
// Search sequencer: state machine driving the table datapath.
`timescale 1ns / 1ps

module nts_ctrl
   import nts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           accept;
   logic           nb_hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // neighbor brackets the target on the side being probed
   assign nb_hit    = status.side_high ? status.tgt_lt_q : status.tgt_gt_q;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.command == CMD_QUERY) begin
               state_in = status.count_zero ? ST_DONE : ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = status.tgt_gt_q ? ST_LAST : ST_DONE;
         end
         ST_LAST: begin
            state_in = status.tgt_lt_q ? ST_MID : ST_DONE;
         end
         ST_MID: begin
            state_in = status.lo_lt_hi ? ST_PROBE : ST_DONE;
         end
         ST_PROBE: begin
            if (status.q_eq) begin
               state_in = ST_DONE;
            end else if (status.tgt_lt_q) begin
               state_in = status.mid_nz ? ST_NEIGHBOR : ST_MID;
            end else begin
               state_in = status.mid_inc_lt_n ? ST_NEIGHBOR : ST_MID;
            end
         end
         ST_NEIGHBOR: begin
            state_in = nb_hit ? ST_PICK : ST_MID;
         end
         ST_PICK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd         = '0;
      cmd.rd_sel  = RD_FIRST;
      cmd.res_sel = RES_ZERO;
      cmd.accept  = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.command == CMD_QUERY) begin
               if (status.count_zero) begin
                  cmd.set_result = 1'b1;
                  cmd.res_sel    = RES_EMPTY;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (status.tgt_gt_q) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
            end else begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_ZERO;
            end
         end
         ST_LAST: begin
            if (status.tgt_lt_q) begin
               cmd.init_bounds = 1'b1;
            end else begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_LAST;
            end
         end
         ST_MID: begin
            if (status.lo_lt_hi) begin
               cmd.set_mid = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_MID;
            end else begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_MID;
            end
         end
         ST_PROBE: begin
            if (status.q_eq) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_MID;
            end else if (status.tgt_lt_q) begin
               if (status.mid_nz) begin
                  cmd.latch_vmid = 1'b1;
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = RD_DEC;
               end else begin
                  cmd.hi_to_mid = 1'b1;
               end
            end else begin
               if (status.mid_inc_lt_n) begin
                  cmd.latch_vmid = 1'b1;
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = RD_INC;
               end else begin
                  cmd.lo_to_inc = 1'b1;
               end
            end
         end
         ST_NEIGHBOR: begin
            if (nb_hit) begin
               cmd.latch_diff = 1'b1;
            end else if (status.side_high) begin
               cmd.lo_to_inc = 1'b1;
            end else begin
               cmd.hi_to_mid = 1'b1;
            end
         end
         ST_PICK: begin
            cmd.set_result = 1'b1;
            cmd.res_sel    = RES_PICK;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd.accept = 1'b0;
         end
      endcase
   end

endmodule

// File: hw/rtl/nts_datapath.sv
// Timestamp table memory, search bounds, comparators and response register.
`timescale 1ns / 1ps

module nts_datapath
   import nts_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_command,
   input  logic [STAMP_W-1:0] req_stamp_value,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_nearest_index,
   output logic               rsp_table_empty,
   output logic               rsp_appends_dropped
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [STAMP_W-1:0] mem [TABLE_DEPTH];

   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [STAMP_W-1:0] target_ff;
   logic [CW-1:0]      lo_ff, hi_ff, mid_ff;
   logic [STAMP_W-1:0] vmid_ff, q_ff;
   logic               side_ff;
   logic [STAMP_W-1:0] dlo_ff, dhi_ff;
   logic [CW-1:0]      res_ff, res_in;
   logic               empty_ff;
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic               rsp_empty_ff, rsp_drop_ff;

   logic [CW:0]        bound_sum;
   logic [CW-1:0]      mid_new, mid_dec, mid_inc, last_idx;
   logic [CW:0]        mid_inc_w;
   logic [AW-1:0]      rd_addr;
   logic               do_append;
   logic               pick_ge;
   logic [CW+INDEX_W-1:0] res_wide;

   // index arithmetic
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_new   = bound_sum[CW:1];
   assign mid_dec   = mid_ff - 1'b1;
   assign mid_inc_w = {1'b0, mid_ff} + 1'b1;
   assign mid_inc   = mid_inc_w[CW-1:0];
   assign last_idx  = count_ff - 1'b1;

   // read address mux
   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = last_idx[AW-1:0];
         RD_MID:   rd_addr = mid_new[AW-1:0];
         RD_DEC:   rd_addr = mid_dec[AW-1:0];
         RD_INC:   rd_addr = mid_inc[AW-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // table memory: append write, registered read
   assign do_append = cmd.accept && req_command == CMD_APPEND && count_ff < DEPTH_C;

   always_ff @(posedge clock) begin
      if (do_append) begin
         mem[count_ff[AW-1:0]] <= req_stamp_value;
      end
      if (cmd.rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   // fill count and overflow flag
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.accept && req_command == CMD_CLEAR) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.accept && req_command == CMD_APPEND) begin
         if (count_ff < DEPTH_C) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      if (cmd.accept && req_command == CMD_QUERY) begin
         target_ff <= req_stamp_value;
      end
      if (cmd.init_bounds) begin
         lo_ff  <= '0;
         hi_ff  <= count_ff;
         mid_ff <= '0;
      end
      if (cmd.set_mid) begin
         mid_ff <= mid_new;
      end
      if (cmd.hi_to_mid) begin
         hi_ff <= mid_ff;
      end
      if (cmd.lo_to_inc) begin
         lo_ff <= mid_inc;
      end
      if (cmd.latch_vmid) begin
         vmid_ff <= q_ff;
         side_ff <= (target_ff >= q_ff);
      end
      // distances to the two bracketing entries
      if (cmd.latch_diff) begin
         if (side_ff) begin
            dlo_ff <= target_ff - vmid_ff;
            dhi_ff <= q_ff - target_ff;
         end else begin
            dlo_ff <= target_ff - q_ff;
            dhi_ff <= vmid_ff - target_ff;
         end
      end
   end

   // result select; a tie goes to the higher index
   assign pick_ge = (dlo_ff >= dhi_ff);

   always_comb begin
      case (cmd.res_sel)
         RES_ZERO:  res_in = '0;
         RES_LAST:  res_in = last_idx;
         RES_MID:   res_in = mid_ff;
         RES_PICK:  res_in = side_ff ? (pick_ge ? mid_inc : mid_ff)
                                     : (pick_ge ? mid_ff : mid_dec);
         RES_EMPTY: res_in = '0;
         default:   res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_ff   <= res_in;
         empty_ff <= (cmd.res_sel == RES_EMPTY);
      end
   end

   // response register
   assign res_wide = {{INDEX_W{1'b0}}, res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_idx_ff   <= res_wide[INDEX_W-1:0];
         rsp_empty_ff <= empty_ff;
         rsp_drop_ff  <= ovf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_nearest_index   = rsp_idx_ff;
   assign rsp_table_empty     = rsp_empty_ff;
   assign rsp_appends_dropped = rsp_drop_ff;

   // status to the sequencer
   always_comb begin
      status              = '0;
      status.command      = req_command;
      status.count_zero   = (count_ff == '0);
      status.tgt_lt_q     = (target_ff < q_ff);
      status.tgt_gt_q     = (target_ff > q_ff);
      status.q_eq         = (target_ff == q_ff);
      status.lo_lt_hi     = (lo_ff < hi_ff);
      status.mid_nz       = (mid_ff != '0);
      status.mid_inc_lt_n = (mid_inc_w < {1'b0, count_ff});
      status.side_high    = side_ff;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: test/nearest_timestamp_search_top_tb.sv
// Self-checking testbench for the nearest timestamp search block.
`timescale 1ns / 1ps

module nearest_timestamp_search_top_tb;
   import nts_pkg::*;

   // command code 3 has no meaning and must be ignored
   localparam logic [1:0] CMD_UNDEFINED = 2'd3;

   localparam logic [STAMP_W-1:0] STAMP_MAX   = {STAMP_W{1'b1}};
   localparam int                 CYCLE_LIMIT = 1_000_000;
   localparam int                 RANDOM_REQS = 1600;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               empty;
      logic               dropped;
   } nearest_answer_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [STAMP_W-1:0] stamp;
      logic               known;
      nearest_answer_type answer;
   } directed_row_type;

   localparam nearest_answer_type NO_ANSWER = '{'0, 1'b0, 1'b0};

   logic clock;
   logic reset;

   nts_req_if req_if ();
   nts_rsp_if rsp_if ();

   nearest_timestamp_search_top #(
      .TABLE_DEPTH(TABLE_DEPTH_DEF)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // mirror of the block's table and flags
   logic [STAMP_W-1:0] stamp_mirror [TABLE_DEPTH_DEF];
   int                 fill_count;
   logic               dropped_flag;

   nearest_answer_type pending_answers [$];

   bit steady;
   int mismatch_count;
   int cycle_count;
   int requests_counted;
   int query_count;
   int ignored_count;
   int response_count;

   // directed requests; answers typed in only where they are obvious
   directed_row_type script [0:23] = '{
      '{CMD_QUERY,     63'd0,     1'b1, '{10'd0, 1'b1, 1'b0}},
      '{CMD_UNDEFINED, STAMP_MAX, 1'b0, NO_ANSWER},
      '{CMD_QUERY,     STAMP_MAX, 1'b1, '{10'd0, 1'b1, 1'b0}},
      '{CMD_APPEND,    63'd0,     1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd0,     1'b1, '{10'd0, 1'b0, 1'b0}},
      '{CMD_QUERY,     STAMP_MAX, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{CMD_APPEND,    63'd100,   1'b0, NO_ANSWER},
      '{CMD_APPEND,    63'd200,   1'b0, NO_ANSWER},
      '{CMD_APPEND,    63'd300,   1'b0, NO_ANSWER},
      '{CMD_APPEND,    STAMP_MAX, 1'b0, NO_ANSWER},
      '{CMD_QUERY,     STAMP_MAX, 1'b1, '{10'd4, 1'b0, 1'b0}},
      '{CMD_QUERY,     63'd150,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd200,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd120,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd299,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd1,     1'b0, NO_ANSWER},
      '{CMD_CLEAR,     63'd0,     1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd5,     1'b1, '{10'd0, 1'b1, 1'b0}},
      '{CMD_APPEND,    63'd500,   1'b0, NO_ANSWER},
      '{CMD_APPEND,    63'd400,   1'b0, NO_ANSWER},
      '{CMD_APPEND,    63'd600,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd450,   1'b0, NO_ANSWER},
      '{CMD_QUERY,     63'd650,   1'b1, '{10'd2, 1'b0, 1'b0}},
      '{CMD_CLEAR,     STAMP_MAX, 1'b0, NO_ANSWER}
   };

   function automatic logic [STAMP_W-1:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[STAMP_W-1:0];
   endfunction

   // ascending successor: small steps, big steps or a repeat, clamped at the top
   function automatic logic [STAMP_W-1:0] next_sorted(input logic [STAMP_W-1:0] prev,
                                                      input bit fine);
      logic [63:0] step;
      logic [63:0] sum;
      if ($urandom_range(0, 9) == 0)
         step = '0;
      else if (fine || $urandom_range(0, 1) == 0)
         step = 64'($urandom() >> $urandom_range(0, 31));
      else
         step = {1'b0, rand_stamp()} >> $urandom_range(8, 62);
      sum = {1'b0, prev} + step;
      if (sum > {1'b0, STAMP_MAX})
         sum = {1'b0, STAMP_MAX};
      return sum[STAMP_W-1:0];
   endfunction

   // query target aimed at the interesting spots of the current table
   function automatic logic [STAMP_W-1:0] pick_target();
      int                 k;
      logic [STAMP_W-1:0] lo_v;
      logic [STAMP_W-1:0] hi_v;
      logic [63:0]        span;
      logic [63:0]        offs;
      if (fill_count == 0)
         return rand_stamp();
      k = $urandom_range(0, fill_count - 1);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return STAMP_MAX;
         2: return stamp_mirror[k];
         3: return stamp_mirror[k] + 1'b1;
         4: return stamp_mirror[k] - 1'b1;
         5: begin
            if (k + 1 >= fill_count)
               return stamp_mirror[k];
            lo_v = stamp_mirror[k];
            hi_v = stamp_mirror[k+1];
            return lo_v + ((hi_v - lo_v) >> 1);
         end
         6, 7: begin
            lo_v = stamp_mirror[0];
            hi_v = stamp_mirror[fill_count-1];
            span = {1'b0, hi_v - lo_v} + 64'd1;
            offs = {1'b0, rand_stamp()} % span;
            return lo_v + offs[STAMP_W-1:0];
         end
         default: return rand_stamp();
      endcase
   endfunction

   // target lies strictly between the two entries; ties go high
   function automatic int closer_of_pair(input int lo_i, input int hi_i,
                                         input logic [STAMP_W-1:0] target);
      logic [STAMP_W-1:0] below;
      logic [STAMP_W-1:0] above;
      below = target - stamp_mirror[lo_i];
      above = stamp_mirror[hi_i] - target;
      return (below >= above) ? hi_i : lo_i;
   endfunction

   // clamp at both ends, then binary search with neighbor checks
   function automatic int nearest_entry(input int n, input logic [STAMP_W-1:0] target);
      int lo_i;
      int hi_i;
      int mid_i;
      lo_i  = 0;
      hi_i  = n;
      mid_i = 0;
      if (target <= stamp_mirror[0])
         return 0;
      if (target >= stamp_mirror[n-1])
         return n - 1;
      while (lo_i < hi_i) begin
         mid_i = (lo_i + hi_i) / 2;
         if (stamp_mirror[mid_i] == target)
            return mid_i;
         if (target < stamp_mirror[mid_i]) begin
            if (mid_i > 0 && target > stamp_mirror[mid_i-1])
               return closer_of_pair(mid_i - 1, mid_i, target);
            hi_i = mid_i;
         end else begin
            if (mid_i + 1 < n && target < stamp_mirror[mid_i+1])
               return closer_of_pair(mid_i, mid_i + 1, target);
            lo_i = mid_i + 1;
         end
      end
      return mid_i;
   endfunction

   // update the mirror for an accepted request, queue the answer of a query
   task automatic apply_to_mirror(input logic [1:0] cmd, input logic [STAMP_W-1:0] stamp,
                                  input logic known, input nearest_answer_type answer);
      nearest_answer_type want;
      int                 hit;
      case (cmd)
         CMD_CLEAR: begin
            fill_count   = 0;
            dropped_flag = 1'b0;
         end
         CMD_APPEND: begin
            if (fill_count < TABLE_DEPTH_DEF) begin
               stamp_mirror[fill_count] = stamp;
               fill_count++;
            end else begin
               dropped_flag = 1'b1;
            end
         end
         CMD_QUERY: begin
            query_count++;
            if (known) begin
               want = answer;
            end else if (fill_count == 0) begin
               want = '{'0, 1'b1, dropped_flag};
            end else begin
               hit  = nearest_entry(fill_count, stamp);
               want = '{hit[INDEX_W-1:0], 1'b0, dropped_flag};
            end
            pending_answers = {pending_answers, want};
         end
         default: ignored_count++;
      endcase
      if (cmd != CMD_UNDEFINED)
         requests_counted++;
   endtask

   // one request: optional gap with valid low, then hold until accepted
   task automatic send_request(input logic [1:0] cmd, input logic [STAMP_W-1:0] stamp,
                               input logic known, input nearest_answer_type answer);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.stamp_value <= stamp;
      do @(posedge clock); while (!req_if.ready);
      apply_to_mirror(cmd, stamp, known, answer);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: random stall before each response, then compare
   initial begin
      int                 stall;
      nearest_answer_type want;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         response_count++;
         if (pending_answers.size() == 0) begin
            $error("response with no query outstanding: index %0d", rsp_if.nearest_index);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.nearest_index !== want.index) begin
               $error("nearest_index: expected %0d, got %0d", want.index,
                      rsp_if.nearest_index);
               mismatch_count++;
            end
            if (rsp_if.table_empty !== want.empty) begin
               $error("table_empty: expected %0b, got %0b", want.empty, rsp_if.table_empty);
               mismatch_count++;
            end
            if (rsp_if.appends_dropped !== want.dropped) begin
               $error("appends_dropped: expected %0b, got %0b", want.dropped,
                      rsp_if.appends_dropped);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int                 r;
      int                 i;
      int                 phase;
      int                 kind;
      int                 fill;
      int                 queries;
      logic [STAMP_W-1:0] prev;
      logic [STAMP_W-1:0] value;

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.command     <= CMD_CLEAR;
      req_if.stamp_value <= '0;
      steady             = 1'b0;
      fill_count         = 0;
      dropped_flag       = 1'b0;
      mismatch_count     = 0;
      requests_counted   = 0;
      query_count        = 0;
      ignored_count      = 0;
      response_count     = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (r = 0; r < $size(script); r++)
         send_request(script[r].cmd, script[r].stamp, script[r].known, script[r].answer);
      requests_counted = 0;

      // random phases: mostly sorted fills followed by queries; one fill runs past
      // the table depth; some fills unsorted, some left empty
      phase = 0;
      while (requests_counted < RANDOM_REQS) begin
         steady = ($urandom_range(0, 3) == 0);
         kind   = $urandom_range(0, 9);
         if (phase == 2)
            fill = TABLE_DEPTH_DEF + $urandom_range(1, 4);
         else if (kind == 1)
            fill = 0;
         else if ($urandom_range(0, 7) == 0)
            fill = $urandom_range(41, 200);
         else
            fill = $urandom_range(1, 40);

         // now and then the table is extended without a clear
         if (phase == 2 || $urandom_range(0, 7) != 0)
            send_request(CMD_CLEAR, rand_stamp(), 1'b0, NO_ANSWER);

         prev = rand_stamp() >> $urandom_range((phase == 2) ? 20 : 0, 62);
         for (i = 0; i < fill; i++) begin
            if (kind == 0 && phase != 2)
               value = rand_stamp();
            else
               value = next_sorted(prev, phase == 2);
            prev = value;
            send_request(CMD_APPEND, value, 1'b0, NO_ANSWER);
            if ($urandom_range(0, 31) == 0)
               send_request(CMD_UNDEFINED, rand_stamp(), 1'b0, NO_ANSWER);
         end

         queries = (phase == 2) ? 24 : $urandom_range(4, 16);
         for (i = 0; i < queries; i++) begin
            case ($urandom_range(0, 19))
               0: send_request(CMD_UNDEFINED, rand_stamp(), 1'b0, NO_ANSWER);
               1: send_request(CMD_APPEND, rand_stamp(), 1'b0, NO_ANSWER);
               default: ;
            endcase
            send_request(CMD_QUERY, pick_target(), 1'b0, NO_ANSWER);
         end
         phase++;
      end

      req_if.valid <= 1'b0;
      steady = 1'b0;

      // drain, then allow the longest search to finish
      while (pending_answers.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d random requests over %0d table fills, one past full depth;",
               requests_counted, phase);
      $display("%0d queries answered, %0d undefined codes ignored, %0d mismatches",
               response_count, ignored_count, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/nts_pkg.sv
hw/rtl/nts_if.sv
hw/rtl/nts_ctrl.sv
hw/rtl/nts_datapath.sv
hw/rtl/nearest_timestamp_search_top.sv
test/nearest_timestamp_search_top_tb.sv
